@@ rtl/assert_macros.svh @@
// Assertion macros shared by the ticket table RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define FCT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCT_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define FCT_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/fct_pkg.sv @@
// Types and constants of the fence completion ticket table.
// No dependencies; imported by the top level of the block.
package fct_pkg;

    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_REG_FAIL = 3'd1;
    localparam logic [2:0] CMD_FENCE    = 3'd2;
    localparam logic [2:0] CMD_QUERY    = 3'd3;
    localparam logic [2:0] CMD_CANCEL   = 3'd4;
    localparam logic [2:0] CMD_FRAME    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_LATE = 2'd3;

    localparam logic [3:0] CANCEL_ERR_RESET = 4'd1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] fence;
        logic [47:0] bytes;
        logic [3:0]  error_code;
        logic [15:0] ticket_id;
        logic [2:0]  slot;
    } fct_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] issued_id;
        logic [63:0] ticket_fence;
        logic        done_res;
        logic        success;
        logic [47:0] ok_bytes;
        logic [3:0]  result_error;
        logic        has_error;
        logic        any_pending;
        logic [63:0] done_fence;
        logic [63:0] last_fence;
    } fct_out_t;

endpackage

@@ rtl/fct_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/fence_completion_ticket_table.sv @@
// Top level of the fence completion ticket table: handshakes, sequencer, entry memory.
// Depends on fct_pkg, fct_ram and assert_macros.svh.
//
//  Channel  | Direction | Payload    | Handshake
//  s_       | in        | fct_in_t   | s_valid / s_ready
//  m_       | out       | fct_out_t  | m_valid / m_ready
//  cfg_     | in        | 4-bit data | cfg_valid / cfg_ready
//
// Every command scans the whole table, one entry per cycle, through the single read port
// of the entry RAM before its result is formed. Reset is synchronous, active low, and clears
// the valid bits (flip-flops), the counters and the fences at once; there is no clearing
// pass. A new transaction is taken only once the previous result has left the output
// register, so a stalled output holds the result and keeps s_ready low.
`include "assert_macros.svh"
module fence_completion_ticket_table
    import fct_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int ID_BITS     = 16,
    parameter int FRAME_SLOTS = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fct_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fct_out_t m_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [3:0] cfg_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    // Entry word: id, fence, bytes, flags(err,ok,done), error, slot.
    localparam int EW = ID_BITS + 64 + 48 + 3 + 4 + SW;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_OUT} state_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [63:0]        fence;
        logic [47:0]        bytes;
        logic               f_err;
        logic               f_ok;
        logic               f_done;
        logic [3:0]         err;
        logic [SW-1:0]      slot;
    } entry_t;

    state_t               state_reg;
    fct_in_t              item_reg;
    logic [AW:0]          rd_cnt_reg;      // read address counter (covers depth)
    logic                 rd_vld_reg;      // RAM output holds entry of rd_idx_reg
    logic [AW-1:0]        rd_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] pend_reg;      // valid and not done, per entry
    logic [ID_BITS-1:0]   next_id_reg;
    logic [63:0]          comp_fence_reg;
    logic [63:0]          last_fence_reg;
    logic [SW-1:0]        cur_slot_reg;
    logic [3:0]           cancel_err_reg;
    logic                 hit_reg;
    logic [AW-1:0]        hit_idx_reg;
    entry_t               hit_ent_reg;
    logic                 free_reg;
    logic [AW-1:0]        free_idx_reg;
    fct_out_t             out_reg;
    logic                 out_vld_reg;

    entry_t               rd_ent;
    logic [EW-1:0]        rd_word;
    logic                 we;
    logic [AW-1:0]        waddr;
    entry_t               wdata;
    logic [ID_BITS-1:0]   key_id;
    logic [SW-1:0]        frame_slot;
    logic                 entry_hit;
    fct_out_t             out_next;

    assign rd_ent = entry_t'(rd_word);

    fct_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (EW'(wdata)),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (rd_word)
    );

    assign s_ready   = (state_reg == S_IDLE) && !out_vld_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    // Register commands look up the next id; query and cancel the given one.
    // The slot is reduced through a constant table of its eight possible values.
    always_comb begin
        if (item_reg.cmd == CMD_REGISTER || item_reg.cmd == CMD_REG_FAIL) begin
            key_id = next_id_reg;
        end else begin
            key_id = ID_BITS'(item_reg.ticket_id);
        end
        frame_slot = '0;
        for (int s = 0; s < 8; s++) begin
            if (item_reg.slot == 3'(s)) begin
                frame_slot = SW'(s % FRAME_SLOTS);
            end
        end
    end

    assign entry_hit = rd_vld_reg && valid_reg[rd_idx_reg] && (rd_ent.id == key_id);

    // Scan writes complete pending entries in place; apply writes register and cancel.
    always_comb begin
        we    = 1'b0;
        waddr = rd_idx_reg;
        wdata = rd_ent;
        if (state_reg == S_SCAN && rd_vld_reg && item_reg.cmd == CMD_FENCE
            && pend_reg[rd_idx_reg] && rd_ent.fence <= item_reg.fence) begin
            we           = 1'b1;
            wdata.f_done = 1'b1;
            wdata.f_ok   = 1'b1;
            wdata.f_err  = 1'b0;
            wdata.err    = 4'd0;
        end else if (state_reg == S_APPLY) begin
            waddr = hit_reg ? hit_idx_reg : free_idx_reg;
            wdata = hit_ent_reg;
            if (item_reg.cmd == CMD_REGISTER || item_reg.cmd == CMD_REG_FAIL) begin
                we         = hit_reg || free_reg;
                wdata.id   = next_id_reg;
                wdata.slot = cur_slot_reg;
                if (item_reg.cmd == CMD_REGISTER) begin
                    wdata.fence  = item_reg.fence;
                    wdata.bytes  = item_reg.bytes;
                    wdata.f_done = 1'b0;
                    wdata.f_ok   = 1'b0;
                    wdata.f_err  = 1'b0;
                    wdata.err    = 4'd0;
                end else begin
                    wdata.fence  = comp_fence_reg;
                    wdata.bytes  = 48'd0;
                    wdata.f_done = 1'b1;
                    wdata.f_ok   = 1'b0;
                    wdata.f_err  = 1'b1;
                    wdata.err    = item_reg.error_code;
                end
            end else if (item_reg.cmd == CMD_CANCEL) begin
                we           = hit_reg && !hit_ent_reg.f_done;
                wdata.f_done = 1'b1;
                wdata.f_ok   = 1'b0;
                wdata.f_err  = 1'b1;
                wdata.err    = cancel_err_reg;
            end
        end
    end

    // Result of the command, taken into the output register in the apply cycle.
    always_comb begin
        out_next            = '0;
        out_next.status     = ST_OK;
        out_next.done_fence = comp_fence_reg;
        out_next.last_fence = last_fence_reg;
        case (item_reg.cmd)
            CMD_REGISTER, CMD_REG_FAIL: begin
                if (we) begin
                    out_next.last_fence   = wdata.fence;
                    out_next.ticket_fence = wdata.fence;
                    out_next.issued_id    = 16'(next_id_reg);
                end else begin
                    out_next.status = ST_FULL;
                end
            end
            CMD_FENCE: begin
                if (comp_fence_reg < item_reg.fence) begin
                    out_next.done_fence = item_reg.fence;
                end
            end
            CMD_QUERY: begin
                if (!hit_reg) begin
                    out_next.status = ST_NOT_FOUND;
                end else if (hit_ent_reg.f_done) begin
                    out_next.done_res     = 1'b1;
                    out_next.success      = hit_ent_reg.f_ok;
                    out_next.ok_bytes     = hit_ent_reg.f_ok ? hit_ent_reg.bytes : 48'd0;
                    out_next.has_error    = hit_ent_reg.f_err;
                    out_next.result_error = hit_ent_reg.f_err ? hit_ent_reg.err : 4'd0;
                end
            end
            CMD_CANCEL: begin
                if (!hit_reg) begin
                    out_next.status = ST_NOT_FOUND;
                end else if (hit_ent_reg.f_done) begin
                    out_next.status = ST_TOO_LATE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            rd_cnt_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            valid_reg      <= '0;
            pend_reg       <= '0;
            next_id_reg    <= '0;
            comp_fence_reg <= '0;
            last_fence_reg <= '0;
            cur_slot_reg   <= '0;
            cancel_err_reg <= CANCEL_ERR_RESET;
            out_vld_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cancel_err_reg <= cfg_data;
            end
            if (state_reg == S_OUT) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        item_reg   <= s_data;
                        rd_cnt_reg <= '0;
                        rd_vld_reg <= 1'b0;
                        hit_reg    <= 1'b0;
                        free_reg   <= 1'b0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    rd_vld_reg <= (rd_cnt_reg < (AW+1)'(TABLE_DEPTH));
                    rd_idx_reg <= rd_cnt_reg[AW-1:0];
                    if (rd_cnt_reg < (AW+1)'(TABLE_DEPTH)) begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    if (entry_hit && !hit_reg) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                        hit_ent_reg <= rd_ent;
                    end
                    if (rd_vld_reg && !valid_reg[rd_idx_reg] && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= rd_idx_reg;
                    end
                    if (we) begin
                        pend_reg[rd_idx_reg] <= 1'b0;
                    end
                    if (rd_vld_reg && item_reg.cmd == CMD_FRAME && valid_reg[rd_idx_reg]
                        && rd_ent.slot == frame_slot) begin
                        valid_reg[rd_idx_reg] <= 1'b0;
                        pend_reg[rd_idx_reg]  <= 1'b0;
                    end
                    if (rd_vld_reg && rd_idx_reg == AW'(TABLE_DEPTH - 1)) begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    out_reg <= out_next;
                    case (item_reg.cmd)
                        CMD_REGISTER, CMD_REG_FAIL: begin
                            if (we) begin
                                valid_reg[waddr] <= 1'b1;
                                pend_reg[waddr]  <= (item_reg.cmd == CMD_REGISTER);
                                next_id_reg      <= next_id_reg + 1'b1;
                                last_fence_reg   <= wdata.fence;
                            end
                        end
                        CMD_FENCE: begin
                            if (comp_fence_reg < item_reg.fence) begin
                                comp_fence_reg <= item_reg.fence;
                            end
                        end
                        CMD_CANCEL: begin
                            if (hit_reg && !hit_ent_reg.f_done) begin
                                pend_reg[hit_idx_reg] <= 1'b0;
                            end
                        end
                        CMD_FRAME: begin
                            cur_slot_reg <= frame_slot;
                        end
                        default: begin
                        end
                    endcase
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // Pending flag is taken after all table updates landed.
                    out_reg.any_pending <= |pend_reg;
                    state_reg           <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `FCT_ASSERT_IMP(a_pend_valid, aclk, aresetn, 1'b1, (pend_reg & ~valid_reg) == '0, "pending entry not valid")
    `FCT_ASSERT_NXT(a_out_after_seq, aclk, aresetn, state_reg == S_OUT, out_vld_reg, "result not raised")
    `FCT_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready, "accept while busy")
endmodule
